@@ rtl/gf2mn_pkg.sv @@
`default_nettype none

package gf2mn_pkg;

  // fixed field widths
  localparam int RowWidth   = 64;
  localparam int CountWidth = 7;

  // default chain length, one cell per pivot column
  localparam int MaxColumnsDefault = 64;

  // reset value of the column count register
  localparam logic [CountWidth-1:0] ColumnCountReset = CountWidth'(64);

  // control part of a row token moving along the chain
  typedef struct packed {
    logic valid;
    logic last;
    logic absorbed;
  } tok_ctrl_t;

endpackage

`default_nettype wire

@@ rtl/gf2mn_cell.sv @@
`default_nettype none

module gf2mn_cell
  import gf2mn_pkg::*;
#(
  parameter int MAX_COLUMNS = MaxColumnsDefault,
  parameter int PIVOT       = 0
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   en,
  input  wire tok_ctrl_t              in_ctrl,
  input  wire logic [MAX_COLUMNS-1:0] in_row,
  output tok_ctrl_t                   out_ctrl,
  output logic      [MAX_COLUMNS-1:0] out_row
);

  logic [MAX_COLUMNS-1:0] basis_row;
  logic                   basis_valid;

  logic                   hit;
  logic                   take;
  logic [MAX_COLUMNS-1:0] row_next;
  tok_ctrl_t              ctrl_next;

  // the row carries this pivot bit: reduce or claim the slot
  assign hit  = in_ctrl.valid && in_row[PIVOT];
  assign take = hit && !basis_valid;

  always_comb begin
    ctrl_next = in_ctrl;
    row_next  = in_row;
    if (take) begin
      ctrl_next.absorbed = 1'b1;
      row_next           = '0;
    end else if (hit) begin
      row_next = in_row ^ basis_row;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      basis_valid <= 1'b0;
      out_ctrl    <= '0;
    end else if (en) begin
      out_ctrl <= ctrl_next;
      // last row of a matrix empties the slot behind it
      if (in_ctrl.valid && in_ctrl.last) begin
        basis_valid <= 1'b0;
      end else if (take) begin
        basis_valid <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_row <= row_next;
      if (take) begin
        basis_row <= in_row;
      end
    end
  end

  // stored row has its highest set bit at this pivot
  a_basis_pivot : assert property (@(posedge clk) disable iff (rst)
    basis_valid |-> (basis_row >> PIVOT) == MAX_COLUMNS'(1))
    else $error("basis row pivot mismatch");

  // an absorbed row leaves nothing for later cells
  a_absorbed_zero : assert property (@(posedge clk) disable iff (rst)
    out_ctrl.absorbed |-> out_row == '0)
    else $error("absorbed row not cleared");

  a_absorbed_valid : assert property (@(posedge clk) disable iff (rst)
    !out_ctrl.valid |-> !out_ctrl.absorbed)
    else $error("absorbed flag on empty token");

endmodule

`default_nettype wire

@@ rtl/gf2_matrix_nullity.sv @@
// gf2_matrix_nullity: rank and nullity of a 0/1 matrix over GF(2)
//
// input channel (in_valid/in_ready): one matrix row per transaction,
// row_bits bit j is column j, last_row marks the final row of a matrix.
// output channel (out_valid/out_ready): one transaction per matrix,
// carrying rank and nullity = columns - rank (zero if rank is larger).
// cfg_write/cfg_data set column_count; columns at or above it are dropped,
// a value above MAX_COLUMNS acts as MAX_COLUMNS. write only while idle.
//
// rows walk a chain of MAX_COLUMNS cells, one cell per pivot column from
// the highest down, one cell per cycle unless stalled. a new row is taken
// every cycle unless stalled. the last row of a matrix passes every cell
// register of the chain and then the output register before its result.
// a stalled receiver holds the result; the chain keeps moving until the
// next last row reaches its end, then the whole chain and in_ready hold.
// reset empties every cell, clears the rank count and out_valid, and
// sets column_count to 64.
`default_nettype none

module gf2_matrix_nullity
  import gf2mn_pkg::*;
#(
  parameter int MAX_COLUMNS = MaxColumnsDefault
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  in_valid,
  output logic                       in_ready,
  input  wire logic [RowWidth-1:0]   row_bits,
  input  wire logic                  last_row,
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output logic      [CountWidth-1:0] nullity,
  output logic      [CountWidth-1:0] rank,
  input  wire logic                  cfg_write,
  input  wire logic [CountWidth-1:0] cfg_data
);

  localparam logic [CountWidth-1:0] MaxCols = CountWidth'(MAX_COLUMNS);

  // configuration
  logic [CountWidth-1:0] column_count;
  logic [CountWidth-1:0] eff_cols;

  always_ff @(posedge clk) begin
    if (rst) begin
      column_count <= ColumnCountReset;
    end else if (cfg_write) begin
      column_count <= cfg_data;
    end
  end

  assign eff_cols = (column_count > MaxCols) ? MaxCols : column_count;

  // mask off unused columns at the chain entry
  logic [MAX_COLUMNS-1:0] col_mask;

  for (genvar j = 0; j < MAX_COLUMNS; j++) begin : g_mask
    assign col_mask[j] = CountWidth'(j) < eff_cols;
  end

  // chain of cells, stage 0 is the entry, stage MAX_COLUMNS the exit
  tok_ctrl_t              chain_ctrl [MAX_COLUMNS+1];
  logic [MAX_COLUMNS-1:0] chain_row  [MAX_COLUMNS+1];
  logic                   adv;
  logic                   stall;

  // hold everything when a finished matrix meets an occupied output
  assign stall    = chain_ctrl[MAX_COLUMNS].valid && chain_ctrl[MAX_COLUMNS].last &&
                    out_valid && !out_ready;
  assign adv      = !stall;
  assign in_ready = adv;

  // valid, last, absorbed
  assign chain_ctrl[0] = {in_valid, last_row, 1'b0};

  assign chain_row[0] = row_bits[MAX_COLUMNS-1:0] & col_mask;

  for (genvar k = 0; k < MAX_COLUMNS; k++) begin : g_cell
    gf2mn_cell #(
      .MAX_COLUMNS (MAX_COLUMNS),
      .PIVOT       (MAX_COLUMNS - 1 - k)
    ) u_cell (
      .clk      (clk),
      .rst      (rst),
      .en       (adv),
      .in_ctrl  (chain_ctrl[k]),
      .in_row   (chain_row[k]),
      .out_ctrl (chain_ctrl[k+1]),
      .out_row  (chain_row[k+1])
    );
  end

  // rank count at the chain exit and the output register
  tok_ctrl_t             exit_ctrl;
  logic [CountWidth-1:0] rank_count;
  logic [CountWidth-1:0] rank_next;

  assign exit_ctrl = chain_ctrl[MAX_COLUMNS];
  assign rank_next = rank_count + CountWidth'(exit_ctrl.absorbed);

  always_ff @(posedge clk) begin
    if (rst) begin
      rank_count <= '0;
      out_valid  <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      if (adv && exit_ctrl.valid) begin
        if (exit_ctrl.last) begin
          rank_count <= '0;
          out_valid  <= 1'b1;
        end else begin
          rank_count <= rank_next;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv && exit_ctrl.valid && exit_ctrl.last) begin
      rank    <= rank_next;
      nullity <= (rank_next > eff_cols) ? '0 : eff_cols - rank_next;
    end
  end

  // a finished matrix never enters the output over an unread result
  a_stall_holds_input : assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready && exit_ctrl.valid && exit_ctrl.last) |-> !in_ready)
    else $error("chain moved over a pending result");

  a_result_from_last : assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(exit_ctrl.valid && exit_ctrl.last))
    else $error("result without a last row");

  a_rank_bound : assert property (@(posedge clk) disable iff (rst)
    out_valid |-> rank <= MaxCols)
    else $error("rank above column limit");

endmodule

`default_nettype wire
